// ----- src/mtc_pkg.sv -----
// Shared constants, types and weight table for the magnetic track centroid block.
`timescale 1ns / 1ps
package mtc_pkg;

	localparam int SENSOR_COUNT_DEF = 4;

	localparam logic [7:0] FUNC_READ = 8'h03;
	localparam logic [7:0] LEN_MAP   = 8'h02;

	localparam logic [1:0] BR_NONE  = 2'd0;
	localparam logic [1:0] BR_LEFT  = 2'd1;
	localparam logic [1:0] BR_RIGHT = 2'd2;

	localparam logic [1:0] MISS_LIMIT = 2'd3;

	localparam int MAP_W   = 16;
	localparam int SUM_W   = 10;
	localparam int CNT_W   = 5;
	localparam int DVD_W   = 17;
	localparam int CENT_W  = 16;
	localparam int FRAC_W  = 8;

	typedef logic signed [7:0] weight_t;

	function automatic weight_t weight(input logic [3:0] b);
		int w;
		w = (b >= 4'd8) ? (int'(b) - 7) * 10 : -(8 - int'(b)) * 10;
		return weight_t'(w);
	endfunction

endpackage

// ----- src/mtc_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mtc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mtc_pkg::DVD_W-1:0]     dividend,
	input  logic [mtc_pkg::CNT_W-1:0]     divisor,
	output logic                          done,
	output logic [mtc_pkg::DVD_W-1:0]     quotient
);

	localparam int DvdW = mtc_pkg::DVD_W;
	localparam int DenW = mtc_pkg::CNT_W;
	localparam int StW  = $clog2(DvdW);

	logic            busy_q;
	logic            done_q;
	logic [StW-1:0]  step_q;
	logic [DenW:0]   rem_q;
	logic [DvdW-1:0] quo_q;
	logic [DenW-1:0] den_q;

	logic [DenW:0]   trial;
	logic            ge;

	assign trial = {rem_q[DenW-1:0], quo_q[DvdW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				den_q  <= divisor;
			end else if (busy_q) begin
				rem_q  <= ge ? (trial - {1'b0, den_q}) : trial;
				quo_q  <= {quo_q[DvdW-2:0], ge};
				step_q <= step_q + StW'(1);
				if (step_q == StW'(DvdW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start && step_q == StW'(DvdW - 1) |=> done_q && !busy_q)
		else $error("divider missed its last step");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && den_q != '0 |-> rem_q < {1'b0, den_q})
		else $error("divider remainder out of range");

endmodule

// ----- src/magnetic_track_centroid_top.sv -----
// Top level of the magnetic track centroid block with per-sensor presence debounce.
// A frame is taken in, then the hit map is scanned bit-serially (one detection point per
// cycle through a shift register), the debounce is updated, the bit-serial divider runs when
// any point is kept, and the result is handed to the output register; a bad frame goes
// straight from intake to the hand-off. The hand-off waits while the output register holds a
// result that has not been taken. A new frame is taken as soon as the previous one has moved
// into the output register.
`timescale 1ns / 1ps
module magnetic_track_centroid_top #(
	parameter int SENSOR_COUNT = mtc_pkg::SENSOR_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         sensor_addr,
	input  logic [7:0]                         func_code,
	input  logic [7:0]                         byte_count,
	input  logic [mtc_pkg::MAP_W-1:0]          hit_map,
	input  logic [1:0]                         branch_select,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               frame_ok,
	output logic [1:0]                         sensor_index,
	output logic [mtc_pkg::MAP_W-1:0]          masked_map,
	output logic signed [mtc_pkg::SUM_W-1:0]   weight_sum,
	output logic [mtc_pkg::CNT_W-1:0]          hit_count,
	output logic signed [mtc_pkg::CENT_W-1:0]  centroid_q8,
	output logic                               track_seen,
	output logic                               track_present
);

	localparam int MapW  = mtc_pkg::MAP_W;
	localparam int SumW  = mtc_pkg::SUM_W;
	localparam int CntW  = mtc_pkg::CNT_W;
	localparam int DvdW  = mtc_pkg::DVD_W;
	localparam int CentW = mtc_pkg::CENT_W;
	localparam int FracW = mtc_pkg::FRAC_W;
	localparam int IdxW  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int PosW  = $clog2(MapW);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_UPD, ST_DIV, ST_DONE} state_t;

	state_t state_q;

	logic [MapW-1:0]        map_q;
	logic                   left_q;
	logic                   mask_q;
	logic                   started_q;
	logic                   ended_q;
	logic [PosW-1:0]        pos_q;
	logic [IdxW-1:0]        idx_q;

	logic                   ok_q;
	logic [1:0]             sidx_q;
	logic [MapW-1:0]        mmap_q;
	logic signed [SumW-1:0] sum_q;
	logic [CntW-1:0]        count_q;
	logic [CentW-1:0]       cent_q;
	logic                   seen_q;
	logic                   pres_q;

	logic [1:0]             miss_q [SENSOR_COUNT];
	logic                   flag_q [SENSOR_COUNT];

	logic                   ov_q;
	logic                   o_ok_q;
	logic [1:0]             o_sidx_q;
	logic [MapW-1:0]        o_map_q;
	logic signed [SumW-1:0] o_sum_q;
	logic [CntW-1:0]        o_cnt_q;
	logic [CentW-1:0]       o_cent_q;
	logic                   o_seen_q;
	logic                   o_pres_q;

	logic                   in_fire;
	logic                   addr_ok;
	logic                   good;
	logic [7:0]             addr_m1;
	logic                   bit_w;
	logic [PosW-1:0]        b_w;
	logic                   keep_w;
	mtc_pkg::weight_t       wt_w;
	logic [SumW-1:0]        mag_w;
	logic                   div_start;
	logic                   div_done;
	logic [DvdW-1:0]        div_quo;
	logic [DvdW-1:0]        dvd_w;
	logic [1:0]             miss_new;
	logic                   pres_new;
	logic                   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign addr_ok  = (sensor_addr != 8'd0) && (sensor_addr <= 8'(SENSOR_COUNT));
	assign good     = (func_code == mtc_pkg::FUNC_READ) && (byte_count == mtc_pkg::LEN_MAP)
		&& addr_ok;
	assign addr_m1  = sensor_addr - 8'd1;

	assign bit_w  = left_q ? map_q[MapW-1] : map_q[0];
	assign b_w    = left_q ? ~pos_q : pos_q;
	assign keep_w = bit_w && !(mask_q && ended_q);
	assign wt_w   = mtc_pkg::weight(b_w);

	assign mag_w     = sum_q[SumW-1] ? (~sum_q + SumW'(1)) : sum_q;
	assign dvd_w     = {mag_w[DvdW-FracW-1:0], {FracW{1'b0}}};
	assign div_start = (state_q == ST_UPD) && (count_q != '0);

	assign miss_new = seen_q ? 2'd0
		: ((miss_q[idx_q] == mtc_pkg::MISS_LIMIT) ? mtc_pkg::MISS_LIMIT : miss_q[idx_q] + 2'd1);
	assign pres_new = (miss_new == mtc_pkg::MISS_LIMIT) ? 1'b0 : (seen_q | flag_q[idx_q]);

	assign out_free = !ov_q || out_ready;

	mtc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_w),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			map_q     <= '0;
			left_q    <= 1'b0;
			mask_q    <= 1'b0;
			started_q <= 1'b0;
			ended_q   <= 1'b0;
			pos_q     <= '0;
			idx_q     <= '0;
			ok_q      <= 1'b0;
			sidx_q    <= '0;
			mmap_q    <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			cent_q    <= '0;
			seen_q    <= 1'b0;
			pres_q    <= 1'b0;
			for (int s = 0; s < SENSOR_COUNT; s++) begin
				miss_q[s] <= '0;
				flag_q[s] <= 1'b0;
			end
			ov_q      <= 1'b0;
			o_ok_q    <= 1'b0;
			o_sidx_q  <= '0;
			o_map_q   <= '0;
			o_sum_q   <= '0;
			o_cnt_q   <= '0;
			o_cent_q  <= '0;
			o_seen_q  <= 1'b0;
			o_pres_q  <= 1'b0;
		end else begin
			if (ov_q && out_ready && (state_q != ST_DONE)) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						map_q     <= hit_map;
						left_q    <= (branch_select == mtc_pkg::BR_LEFT);
						mask_q    <= (branch_select == mtc_pkg::BR_LEFT)
							|| (branch_select == mtc_pkg::BR_RIGHT);
						started_q <= 1'b0;
						ended_q   <= 1'b0;
						pos_q     <= '0;
						idx_q     <= addr_m1[IdxW-1:0];
						ok_q      <= good;
						sidx_q    <= good ? addr_m1[1:0] : 2'd0;
						mmap_q    <= '0;
						sum_q     <= '0;
						count_q   <= '0;
						cent_q    <= '0;
						seen_q    <= 1'b0;
						pres_q    <= 1'b0;
						state_q   <= good ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					map_q  <= left_q ? {map_q[MapW-2:0], 1'b0} : {1'b0, map_q[MapW-1:1]};
					mmap_q <= left_q ? {mmap_q[MapW-2:0], keep_w} : {keep_w, mmap_q[MapW-1:1]};
					if (bit_w) begin
						started_q <= 1'b1;
					end else if (started_q) begin
						ended_q <= 1'b1;
					end
					if (keep_w) begin
						sum_q   <= sum_q + SumW'(wt_w);
						count_q <= count_q + CntW'(1);
						if (b_w != PosW'(MapW - 1)) begin
							seen_q <= 1'b1;
						end
					end
					pos_q <= pos_q + PosW'(1);
					if (pos_q == PosW'(MapW - 1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					miss_q[idx_q] <= miss_new;
					flag_q[idx_q] <= pres_new;
					pres_q        <= pres_new;
					state_q       <= (count_q != '0) ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (div_done) begin
						cent_q  <= sum_q[SumW-1] ? (~div_quo[CentW-1:0] + CentW'(1))
							: div_quo[CentW-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_ok_q   <= ok_q;
						o_sidx_q <= sidx_q;
						o_map_q  <= mmap_q;
						o_sum_q  <= sum_q;
						o_cnt_q  <= count_q;
						o_cent_q <= cent_q;
						o_seen_q <= seen_q;
						o_pres_q <= pres_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = ov_q;
	assign frame_ok      = o_ok_q;
	assign sensor_index  = o_sidx_q;
	assign masked_map    = o_map_q;
	assign weight_sum    = o_sum_q;
	assign hit_count     = o_cnt_q;
	assign centroid_q8   = o_cent_q;
	assign track_seen    = o_seen_q;
	assign track_present = o_pres_q;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !o_ok_q |-> o_map_q == '0 && o_sum_q == '0 && o_cnt_q == '0
			&& o_cent_q == '0 && !o_seen_q && !o_pres_q)
		else $error("bad frame result not cleared");
	a_seen_present: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && o_seen_q |-> o_pres_q)
		else $error("seen track not marked present");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && o_cnt_q == '0 |-> o_cent_q == '0 && o_sum_q == '0 && o_map_q == '0)
		else $error("empty map gave nonzero result");

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the magnetic track centroid block: directed and random frames checked in order.
`timescale 1ns / 1ps
module tb_top;

	localparam int SENSORS       = mtc_pkg::SENSOR_COUNT_DEF;
	localparam int RANDOM_FRAMES = 1500;
	localparam int DRAIN_CYCLES  = 60;

	typedef struct {
		logic               frame_ok;
		logic [1:0]         sensor_index;
		logic [15:0]        masked_map;
		logic signed [9:0]  weight_sum;
		logic [4:0]         hit_count;
		logic signed [15:0] centroid_q8;
		logic               track_seen;
		logic               track_present;
	} centroid_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         sensor_addr;
	logic [7:0]         func_code;
	logic [7:0]         byte_count;
	logic [15:0]        hit_map;
	logic [1:0]         branch_select;
	logic               out_valid;
	logic               out_ready;
	logic               frame_ok;
	logic [1:0]         sensor_index;
	logic [15:0]        masked_map;
	logic signed [9:0]  weight_sum;
	logic [4:0]         hit_count;
	logic signed [15:0] centroid_q8;
	logic               track_seen;
	logic               track_present;

	centroid_t  pending_centroids[$];
	logic [1:0] miss_run[SENSORS];
	logic       present[SENSORS];
	int         mismatches = 0;
	bit         steady = 1'b0;
	int         hold_off_cycles = 0;

	magnetic_track_centroid_top dut (
		.clk, .arst_n, .in_valid, .in_ready, .sensor_addr, .func_code, .byte_count,
		.hit_map, .branch_select, .out_valid, .out_ready, .frame_ok, .sensor_index,
		.masked_map, .weight_sum, .hit_count, .centroid_q8, .track_seen, .track_present
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] keep_left_run(input logic [15:0] m);
		int b;
		logic [15:0] keep;
		b = 15;
		while (b >= 0 && !m[b]) b--;
		if (b < 0) return 16'h0000;
		while (b >= 0 && m[b]) b--;
		if (b < 0) return m;
		keep = 16'hffff << (b + 1);
		return m & keep;
	endfunction

	function automatic logic [15:0] keep_right_run(input logic [15:0] m);
		int b;
		logic [15:0] keep;
		b = 0;
		while (b <= 15 && !m[b]) b++;
		if (b > 15) return 16'h0000;
		while (b <= 15 && m[b]) b++;
		if (b > 15) return m;
		keep = (16'h0001 << b) - 16'h0001;
		return m & keep;
	endfunction

	function automatic centroid_t predict_centroid(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] len, input logic [15:0] map, input logic [1:0] sel);
		centroid_t r;
		int s, sum, cnt, cent;
		logic [15:0] m;
		logic seen;
		r = '{default: '0};
		sum = 0;
		cnt = 0;
		cent = 0;
		if (func != mtc_pkg::FUNC_READ || len != mtc_pkg::LEN_MAP || addr < 1 || addr > SENSORS)
			return r;
		s = addr - 1;
		case (sel)
			mtc_pkg::BR_LEFT: m = keep_left_run(map);
			mtc_pkg::BR_RIGHT: m = keep_right_run(map);
			default: m = map;
		endcase
		for (int b = 0; b < 16; b++) begin
			if (m[b]) begin
				cnt++;
				sum += (b >= 8) ? (b - 7) * 10 : -(8 - b) * 10;
			end
		end
		if (cnt != 0) cent = (sum * 256) / cnt;
		seen = (cnt != 0) && (m[14:0] != 15'd0);
		if (seen) miss_run[s] = 2'd0;
		else if (miss_run[s] < mtc_pkg::MISS_LIMIT) miss_run[s] = miss_run[s] + 2'd1;
		if (miss_run[s] == mtc_pkg::MISS_LIMIT) present[s] = 1'b0;
		else if (seen) present[s] = 1'b1;
		r.frame_ok      = 1'b1;
		r.sensor_index  = s[1:0];
		r.masked_map    = m;
		r.weight_sum    = sum[9:0];
		r.hit_count     = cnt[4:0];
		r.centroid_q8   = cent[15:0];
		r.track_seen    = seen;
		r.track_present = present[s];
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] random_hit_map();
		logic [31:0] run_a, run_b;
		int lo, hi;
		lo = $urandom_range(0, 15);
		hi = $urandom_range(lo, 15);
		run_a = (32'h1 << (hi + 1)) - (32'h1 << lo);
		lo = $urandom_range(0, 15);
		hi = $urandom_range(lo, 15);
		run_b = (32'h1 << (hi + 1)) - (32'h1 << lo);
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'hffff;
			3: return 16'h0001 << $urandom_range(0, 15);
			4, 5: return run_a[15:0];
			6, 7: return run_a[15:0] | run_b[15:0];
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] len, input logic [15:0] map, input logic [1:0] sel);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		sensor_addr   <= addr;
		func_code     <= func;
		byte_count    <= len;
		hit_map       <= map;
		branch_select <= sel;
		do @(posedge clk); while (!in_ready);
		pending_centroids.push_back(predict_centroid(addr, func, len, map, sel));
	endtask

	task automatic flag_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_centroid();
		centroid_t e;
		if (pending_centroids.size() == 0) begin
			mismatches++;
			$display("%0t: result with no pending transaction", $time);
			return;
		end
		e = pending_centroids.pop_front();
		flag_field("frame_ok", 32'(e.frame_ok), 32'(frame_ok));
		flag_field("sensor_index", 32'(e.sensor_index), 32'(sensor_index));
		flag_field("masked_map", 32'(e.masked_map), 32'(masked_map));
		flag_field("weight_sum", 32'(e.weight_sum), 32'(weight_sum));
		flag_field("hit_count", 32'(e.hit_count), 32'(hit_count));
		flag_field("centroid_q8", 32'(e.centroid_q8), 32'(centroid_q8));
		flag_field("track_seen", 32'(e.track_seen), 32'(track_seen));
		flag_field("track_present", 32'(e.track_present), 32'(track_present));
	endtask

	initial begin
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) check_centroid();
			if (hold_off_cycles > 0) begin
				hold = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				stall = idle_len();
				out_ready <= 1'b0;
			end
		end
	end

	task automatic test_bad_frames();
		send_frame(8'd0, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'hffff, mtc_pkg::BR_NONE);
		send_frame(8'd5, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0180, mtc_pkg::BR_LEFT);
		send_frame(8'd255, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h00ff, mtc_pkg::BR_RIGHT);
		send_frame(8'd1, 8'h04, mtc_pkg::LEN_MAP, 16'h0ff0, mtc_pkg::BR_NONE);
		send_frame(8'd2, mtc_pkg::FUNC_READ, 8'h03, 16'h0f00, mtc_pkg::BR_NONE);
		send_frame(8'd3, 8'hfc, 8'hfd, 16'hffff, 2'd3);
	endtask

	task automatic test_branch_masking();
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'hffff, mtc_pkg::BR_NONE);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'hffff, mtc_pkg::BR_LEFT);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0000, mtc_pkg::BR_LEFT);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0000, mtc_pkg::BR_RIGHT);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'hf0f0, mtc_pkg::BR_LEFT);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0f0f, mtc_pkg::BR_RIGHT);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0f0f, mtc_pkg::BR_LEFT);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'hf0f0, mtc_pkg::BR_RIGHT);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0001, mtc_pkg::BR_RIGHT);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h8001, 2'd3);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'hff00, mtc_pkg::BR_NONE);
		send_frame(8'd1, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h00ff, mtc_pkg::BR_NONE);
	endtask

	task automatic test_presence_debounce();
		send_frame(8'd2, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0180, mtc_pkg::BR_NONE);
		send_frame(8'd2, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0000, mtc_pkg::BR_NONE);
		send_frame(8'd2, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0000, mtc_pkg::BR_LEFT);
		send_frame(8'd2, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h8000, mtc_pkg::BR_NONE);
		send_frame(8'd2, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0100, mtc_pkg::BR_NONE);
		send_frame(8'd4, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0001, mtc_pkg::BR_RIGHT);
		send_frame(8'd4, mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP, 16'h0000, mtc_pkg::BR_NONE);
	endtask

	task automatic test_output_backpressure();
		hold_off_cycles = 400;
		for (int i = 0; i < 8; i++)
			send_frame(8'($urandom_range(1, SENSORS)), mtc_pkg::FUNC_READ, mtc_pkg::LEN_MAP,
				random_hit_map(), 2'($urandom_range(0, 3)));
	endtask

	task automatic test_random_frames();
		logic [7:0] addr, func, len;
		for (int i = 0; i < RANDOM_FRAMES; i++) begin
			steady = ((i / 250) % 3) == 2;
			if ($urandom_range(0, 99) < 85) begin
				addr = 8'($urandom_range(1, SENSORS));
				func = mtc_pkg::FUNC_READ;
				len  = mtc_pkg::LEN_MAP;
			end else begin
				addr = ($urandom_range(0, 1) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, SENSORS + 1));
				func = ($urandom_range(0, 2) == 0) ? 8'($urandom) : mtc_pkg::FUNC_READ;
				len  = ($urandom_range(0, 2) == 0) ? 8'($urandom) : mtc_pkg::LEN_MAP;
			end
			send_frame(addr, func, len, random_hit_map(), 2'($urandom_range(0, 3)));
		end
		steady = 1'b0;
	endtask

	initial begin
		for (int s = 0; s < SENSORS; s++) begin
			miss_run[s] = 2'd0;
			present[s]  = 1'b0;
		end
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		sensor_addr   = 8'd0;
		func_code     = 8'd0;
		byte_count    = 8'd0;
		hit_map       = 16'd0;
		branch_select = mtc_pkg::BR_NONE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bad_frames();
		test_branch_masking();
		test_presence_debounce();
		test_output_backpressure();
		test_random_frames();
		in_valid <= 1'b0;
		while (pending_centroids.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
